// File: src/rtre_pkg.sv
// ----------------------------------------------------------------------------
// rtre_pkg: shared types and constants of the range timing register encoder
// Field widths, status codes, divider operand selection and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rtre_pkg;

	// Word fields.
	localparam int BUDGET_W   = 10;
	localparam int PERIOD_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int PWORD_W    = 27;
	localparam int RWORD_W    = 16;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 64;

	// Configuration registers.
	localparam int OSC_W      = 16;
	localparam int PLL_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_FREQ = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLL_CAL  = 1'b1;

	// Divider and datapath widths.
	localparam int DIVIDEND_W = 34;
	localparam int DIVISOR_W  = 24;
	localparam int DIV_CNT_W  = 6;
	localparam int NQ_W       = 24;
	localparam int MS_US_W    = 20;
	localparam int BUD_US_W   = 18;
	localparam int NUM_W      = 30;
	localparam int NUM_SHIFT  = 12;
	localparam int NORM_W     = 32;
	localparam int EXP_W      = 5;
	localparam int MANT_W     = 8;
	localparam int PROD1_W    = 26;

	// Arithmetic constants.
	localparam logic [BUDGET_W-1:0]   BUDGET_MIN     = 10'd10;
	localparam logic [BUDGET_W-1:0]   BUDGET_MAX     = 10'd200;
	localparam logic [MS_US_W-1:0]    US_PER_MS      = 20'd1000;
	localparam logic [MS_US_W-1:0]    CONT_OFFSET_US = 20'd2500;
	localparam logic [MS_US_W-1:0]    LP_OFFSET_US   = 20'd4300;
	localparam logic [DIVIDEND_W-1:0] OSC_DIVIDEND   = 34'h0_4000_0000;
	localparam logic [DIVIDEND_W-1:0] PW_MUL         = 34'd211;
	localparam logic [DIVISOR_W-1:0]  PW_DIV         = 24'd200;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_BAD_BUDGET   = 3'd1,
		ST_ZERO_OSC     = 3'd2,
		ST_PERIOD_SHORT = 3'd3,
		ST_ZERO_DIV     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		DIV_OSC,
		DIV_PW,
		DIV_A,
		DIV_B
	} div_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     err_set;
		status_t  err_code;
		logic     bud_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     nq_en;
		logic     db_en;
		logic     pw_en;
		logic     norm_load;
		logic     norm_step;
		logic     wa_en;
		logic     wb_en;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic osc_zero;
		logic budget_bad;
		logic period_short;
		logic low_power;
		logic div_zero;
		logic div_done;
		logic norm_done;
	} dp_stat_t;

endpackage

// File: src/range_timing_register_encoder.sv
// ----------------------------------------------------------------------------
// range_timing_register_encoder: timing budget to ranging register words
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  budget_ms, period_ms
//   m_*       out        m_tvalid/m_tready  status, low_power, period_word,
//                                           range_a_word, range_b_word
//   cfg_*     in         cfg_we             osc_freq (0), pll_cal (1)
//
// One word is worked on at a time. A word rejected by the input checks goes
// from the check state straight to the done state. A full computation runs
// three divisions in continuous mode and four in low-power mode, all on the
// shared restoring divider, and each exponent search shifts one bit per cycle.
// Reset is asynchronous and clears the configuration registers to zero. The
// result register lets the next word be accepted while a finished result
// waits on m_tready.
// ----------------------------------------------------------------------------
module range_timing_register_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtre_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rtre_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [9:0] budget_ms, [25:10] period_ms, [31:26] zero
	input  logic [rtre_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [2:0] status, [3] low_power, [30:4] period_word, [46:31] range_a_word,
	// [62:47] range_b_word, [63] zero
	output logic [rtre_pkg::OUT_DATA_W-1:0]   m_tdata
);

	rtre_pkg::dp_cmd_t  cmd;
	rtre_pkg::dp_stat_t stat;

	rtre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rtre_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

	// A word is never taken in the cycle right after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is in flight");

	// An error result carries nothing but its status.
	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != rtre_pkg::ST_OK) |-> m_tdata[63:3] == '0)
		else $error("error result with nonzero payload");

	// Continuous mode has no period register value.
	a_cont_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[30:4] == '0)
		else $error("period word set in continuous mode");

	// Only the defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= rtre_pkg::ST_ZERO_DIV)
		else $error("undefined status code");

endmodule

// File: src/rtre_div.sv
// ----------------------------------------------------------------------------
// rtre_div: restoring divider
// Produces one quotient bit per cycle. The operands are captured on start and
// done pulses for one cycle once the quotient is final.
// ----------------------------------------------------------------------------
module rtre_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rtre_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [rtre_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             done,
	output logic [rtre_pkg::DIVIDEND_W-1:0]  quotient
);

	localparam logic [rtre_pkg::DIV_CNT_W-1:0] LAST_STEP =
		rtre_pkg::DIV_CNT_W'(rtre_pkg::DIVIDEND_W - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [rtre_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [rtre_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [rtre_pkg::DIVISOR_W-1:0]     rem_q;
	logic [rtre_pkg::DIVISOR_W-1:0]     dvs_q;
	logic [rtre_pkg::DIVISOR_W:0]       partial;
	logic [rtre_pkg::DIVISOR_W:0]       diff;
	logic                               fits;

	always_comb begin
		partial = {rem_q, quo_q[rtre_pkg::DIVIDEND_W-1]};
		diff    = partial - {1'b0, dvs_q};
		fits    = partial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q  <= cnt_q + 1'b1;
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rtre_pkg::DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[rtre_pkg::DIVISOR_W-1:0] : partial[rtre_pkg::DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: src/rtre_dp.sv
// ----------------------------------------------------------------------------
// rtre_dp: datapath of the range timing register encoder
// Holds the configuration registers, the accepted word, the macro period
// terms, the shared divider, the exponent normalizer and the result register.
// ----------------------------------------------------------------------------
module rtre_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtre_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rtre_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [rtre_pkg::IN_DATA_W-1:0]    in_data,
	input  rtre_pkg::dp_cmd_t                 cmd,
	output rtre_pkg::dp_stat_t                stat,
	output logic [rtre_pkg::OUT_DATA_W-1:0]   out_data
);

	logic [rtre_pkg::OSC_W-1:0]       osc_q;
	logic [rtre_pkg::PLL_W-1:0]       pll_q;
	logic [rtre_pkg::BUDGET_W-1:0]    budget_q;
	logic [rtre_pkg::PERIOD_W-1:0]    period_q;
	rtre_pkg::status_t                status_q;
	logic [rtre_pkg::PROD1_W-1:0]     prod_s1;
	logic [rtre_pkg::DIVIDEND_W-1:0]  prod_s2;
	logic [rtre_pkg::BUD_US_W-1:0]    bud_us_q;
	logic [rtre_pkg::NQ_W-1:0]        nq_q;
	logic [rtre_pkg::DIVISOR_W-1:0]   db_q;
	logic [rtre_pkg::PWORD_W-1:0]     pw_q;
	logic [rtre_pkg::NORM_W-1:0]      norm_q;
	logic [rtre_pkg::EXP_W-1:0]       exp_q;
	logic [rtre_pkg::RWORD_W-1:0]     wa_q;
	logic [rtre_pkg::RWORD_W-1:0]     wb_q;
	logic [rtre_pkg::OUT_DATA_W-1:0]  out_q;

	logic [rtre_pkg::MS_US_W-1:0]     ms_us;
	logic [rtre_pkg::MS_US_W-1:0]     cont_us;
	logic [rtre_pkg::MS_US_W-1:0]     lp_us;
	logic [rtre_pkg::NUM_W-1:0]       num;
	logic [rtre_pkg::NQ_W-1:0]        nq_d;
	logic [rtre_pkg::NQ_W+1:0]        three_nq;
	logic [rtre_pkg::DIVIDEND_W-1:0]  div_dividend;
	logic [rtre_pkg::DIVISOR_W-1:0]   div_divisor;
	logic [rtre_pkg::DIVIDEND_W-1:0]  div_quo;
	logic                             div_done;
	logic [rtre_pkg::NORM_W-1:0]      norm_d;
	logic                             ok;
	logic                             lp_ok;
	logic [rtre_pkg::RWORD_W-1:0]     wa_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q <= '0;
			pll_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rtre_pkg::REG_OSC_FREQ: osc_q <= cfg_wdata;
				rtre_pkg::REG_PLL_CAL:  pll_q <= cfg_wdata[rtre_pkg::PLL_W-1:0];
				default:                osc_q <= osc_q;
			endcase
		end
	end

	always_comb begin
		ms_us   = rtre_pkg::MS_US_W'(budget_q) * rtre_pkg::US_PER_MS;
		cont_us = ms_us - rtre_pkg::CONT_OFFSET_US;
		lp_us   = ms_us - rtre_pkg::LP_OFFSET_US;
		num     = {bud_us_q, {rtre_pkg::NUM_SHIFT{1'b0}}};
		// Only the low bits of 9*q survive the wrap of 2304*q and the shift by six;
		// the macro period is that value times four, so divisor A equals it.
		nq_d     = (div_quo[rtre_pkg::NQ_W-1:0] << 3) + div_quo[rtre_pkg::NQ_W-1:0];
		three_nq = {1'b0, nq_q, 1'b0} + {2'b00, nq_q};
		norm_d   = div_quo[rtre_pkg::NORM_W-1:0] - 1'b1;

		unique case (cmd.div_sel)
			rtre_pkg::DIV_OSC: begin
				div_dividend = rtre_pkg::OSC_DIVIDEND;
				div_divisor  = rtre_pkg::DIVISOR_W'(osc_q);
			end
			rtre_pkg::DIV_PW: begin
				div_dividend = prod_s2;
				div_divisor  = rtre_pkg::PW_DIV;
			end
			rtre_pkg::DIV_A: begin
				div_dividend = rtre_pkg::DIVIDEND_W'(num)
					+ rtre_pkg::DIVIDEND_W'(nq_q >> 1);
				div_divisor  = nq_q;
			end
			default: begin
				div_dividend = rtre_pkg::DIVIDEND_W'(num)
					+ rtre_pkg::DIVIDEND_W'(db_q >> 1);
				div_divisor  = db_q;
			end
		endcase

		wa_d  = {{(rtre_pkg::RWORD_W-rtre_pkg::EXP_W-rtre_pkg::MANT_W){1'b0}},
			exp_q, norm_q[rtre_pkg::MANT_W-1:0]};
		ok    = status_q == rtre_pkg::ST_OK;
		lp_ok = ok && (period_q != '0);

		stat.osc_zero     = osc_q == '0;
		stat.budget_bad   = (budget_q < rtre_pkg::BUDGET_MIN) || (budget_q > rtre_pkg::BUDGET_MAX);
		stat.period_short = (period_q != '0)
			&& (period_q <= rtre_pkg::PERIOD_W'(budget_q));
		stat.low_power    = period_q != '0;
		stat.div_zero     = nq_q <= rtre_pkg::NQ_W'(1);
		stat.div_done     = div_done;
		stat.norm_done    = norm_q[rtre_pkg::NORM_W-1:rtre_pkg::MANT_W] == '0;
	end

	rtre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The period product runs freely; it settles in prod_s2, registered after prod_s1.
	always_ff @(posedge clk) begin
		prod_s1 <= rtre_pkg::PROD1_W'(period_q) * rtre_pkg::PROD1_W'(pll_q);
		prod_s2 <= rtre_pkg::DIVIDEND_W'(prod_s1) * rtre_pkg::PW_MUL;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			budget_q <= in_data[rtre_pkg::BUDGET_W-1:0];
			period_q <= in_data[rtre_pkg::BUDGET_W +: rtre_pkg::PERIOD_W];
			status_q <= rtre_pkg::ST_OK;
		end else if (cmd.err_set) begin
			status_q <= cmd.err_code;
		end
		if (cmd.bud_en)
			bud_us_q <= (period_q == '0) ? cont_us[rtre_pkg::BUD_US_W-1:0]
				: lp_us[rtre_pkg::BUD_US_W:1];
		if (cmd.nq_en)
			nq_q <= nq_d;
		if (cmd.db_en)
			db_q <= three_nq[rtre_pkg::NQ_W+1:2];
		if (cmd.pw_en)
			pw_q <= div_quo[rtre_pkg::PWORD_W-1:0];
		if (cmd.norm_load) begin
			norm_q <= norm_d;
			exp_q  <= '0;
		end else if (cmd.norm_step) begin
			norm_q <= norm_q >> 1;
			exp_q  <= exp_q + 1'b1;
		end
		if (cmd.wa_en)
			wa_q <= wa_d;
		if (cmd.wb_en)
			wb_q <= wa_d;
		if (cmd.out_load)
			out_q <= {1'b0,
				ok ? wb_q : '0,
				ok ? wa_q : '0,
				lp_ok ? pw_q : '0,
				lp_ok,
				status_q};
	end

	assign out_data = out_q;

endmodule

// File: src/rtre_ctrl.sv
// ----------------------------------------------------------------------------
// rtre_ctrl: sequencer of the range timing register encoder
// Steps the datapath through the input checks, the three or four divisions of a
// full computation and its two normalizations, and owns both handshakes.
// ----------------------------------------------------------------------------
module rtre_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  rtre_pkg::dp_stat_t stat,
	output rtre_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_WAIT_OSC,
		S_DIVZ,
		S_WAIT_PW,
		S_WAIT_A,
		S_NORM_A,
		S_WAIT_B,
		S_NORM_B,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.err_code = rtre_pkg::ST_OK;
		cmd.div_sel  = rtre_pkg::DIV_OSC;
		state_d      = state_q;
		s_tready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.bud_en = 1'b1;
				priority if (stat.osc_zero) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = rtre_pkg::ST_ZERO_OSC;
					state_d      = S_DONE;
				end else if (stat.budget_bad) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = rtre_pkg::ST_BAD_BUDGET;
					state_d      = S_DONE;
				end else if (stat.period_short) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = rtre_pkg::ST_PERIOD_SHORT;
					state_d      = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtre_pkg::DIV_OSC;
					state_d       = S_WAIT_OSC;
				end
			end
			S_WAIT_OSC: begin
				if (stat.div_done) begin
					cmd.nq_en = 1'b1;
					state_d   = S_DIVZ;
				end
			end
			S_DIVZ: begin
				cmd.db_en = 1'b1;
				priority if (stat.div_zero) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = rtre_pkg::ST_ZERO_DIV;
					state_d      = S_DONE;
				end else if (stat.low_power) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtre_pkg::DIV_PW;
					state_d       = S_WAIT_PW;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtre_pkg::DIV_A;
					state_d       = S_WAIT_A;
				end
			end
			S_WAIT_PW: begin
				if (stat.div_done) begin
					cmd.pw_en     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtre_pkg::DIV_A;
					state_d       = S_WAIT_A;
				end
			end
			S_WAIT_A: begin
				if (stat.div_done) begin
					cmd.norm_load = 1'b1;
					state_d       = S_NORM_A;
				end
			end
			S_NORM_A: begin
				if (stat.norm_done) begin
					cmd.wa_en     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtre_pkg::DIV_B;
					state_d       = S_WAIT_B;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_WAIT_B: begin
				if (stat.div_done) begin
					cmd.norm_load = 1'b1;
					state_d       = S_NORM_B;
				end
			end
			S_NORM_B: begin
				if (stat.norm_done) begin
					cmd.wb_en = 1'b1;
					state_d   = S_DONE;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_DONE: begin
				// The result register frees up in the cycle its word is taken.
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

// File: tb/sv/range_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_word_checker: result predictor and scoreboard for the encoder
// Snoops the configuration port and both stream channels. For every accepted
// input word it computes the expected status, mode and register words from its
// own copy of the configuration. It then compares each accepted output word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module range_word_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rtre_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rtre_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// [9:0] budget_ms, [25:10] period_ms, [31:26] zero
	input  logic [rtre_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [2:0] status, [3] low_power, [30:4] period_word, [46:31] range_a_word,
	// [62:47] range_b_word, [63] zero
	input  logic [rtre_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              failures,
	output int                              pending,
	output int                              words_checked
);
	import rtre_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                low_power;
		logic [PWORD_W-1:0]  period_word;
		logic [RWORD_W-1:0]  range_a_word;
		logic [RWORD_W-1:0]  range_b_word;
	} timing_words_t;

	logic [OSC_W-1:0] osc_freq_q;
	logic [PLL_W-1:0] pll_cal_q;
	timing_words_t    expected_words[$];

	// Rounded division, minus one, then halved until it fits the mantissa byte.
	function automatic logic [RWORD_W-1:0] encode_range(input logic [31:0] num,
			input logic [31:0] div);
		logic [31:0] v;
		logic [7:0]  e;
		v = (num + (div >> 1)) / div - 32'd1;
		e = 8'd0;
		while (v[31:8] != 24'd0) begin
			v = v >> 1;
			e = e + 8'd1;
		end
		return {e, v[7:0]};
	endfunction

	function automatic timing_words_t predict_timing_words(
			input logic [BUDGET_W-1:0] budget, input logic [PERIOD_W-1:0] period);
		timing_words_t w;
		logic [31:0]   macro;
		logic [31:0]   bud_us;
		logic [31:0]   num;
		logic [31:0]   div_a;
		logic [31:0]   div_b;
		logic [63:0]   pw_full;
		w = '0;
		macro = '0;
		bud_us = '0;
		w.status = ST_OK;
		if (osc_freq_q == '0) begin
			w.status = ST_ZERO_OSC;
		end else begin
			// The products here wrap at 32 bits, except the 64-bit period word product.
			macro = ((32'h4000_0000 / {16'd0, osc_freq_q}) * 32'd2304) >> 6;
			if (budget < BUDGET_MIN || budget > BUDGET_MAX) begin
				w.status = ST_BAD_BUDGET;
			end else if (period == '0) begin
				bud_us = {22'd0, budget} * 32'd1000 - 32'd2500;
			end else if ({6'd0, budget} < period) begin
				w.low_power = 1'b1;
				pw_full = {48'd0, period} * {54'd0, pll_cal_q} * 64'd211 / 64'd200;
				w.period_word = pw_full[PWORD_W-1:0];
				bud_us = ({22'd0, budget} * 32'd1000 - 32'd4300) / 32'd2;
			end else begin
				w.status = ST_PERIOD_SHORT;
			end
		end
		if (w.status == ST_OK) begin
			num = bud_us << NUM_SHIFT;
			div_a = (macro * 32'd16) >> 6;
			div_b = (macro * 32'd12) >> 6;
			if (div_a == '0 || div_b == '0) begin
				w.status = ST_ZERO_DIV;
			end else begin
				w.range_a_word = encode_range(num, div_a);
				w.range_b_word = encode_range(num, div_b);
			end
		end
		if (w.status != ST_OK) begin
			w.low_power = 1'b0;
			w.period_word = '0;
			w.range_a_word = '0;
			w.range_b_word = '0;
		end
		return w;
	endfunction

	always @(posedge clk) begin
		timing_words_t got;
		timing_words_t want;
		if (!arst_n) begin
			osc_freq_q = '0;
			pll_cal_q = '0;
		end else begin
			// Results are checked before new words are queued, so a result can
			// never be matched against a word accepted at the same edge.
			if (m_tvalid && m_tready) begin
				got = timing_words_t'({m_tdata[2:0], m_tdata[3], m_tdata[30:4],
					m_tdata[46:31], m_tdata[62:47]});
				words_checked++;
				if (expected_words.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("result word %0d arrived with nothing expected: %h",
							words_checked, got);
				end else begin
					want = expected_words.pop_front();
					if (got.status !== want.status || got.low_power !== want.low_power ||
							got.period_word !== want.period_word ||
							got.range_a_word !== want.range_a_word ||
							got.range_b_word !== want.range_b_word) begin
						failures++;
						if (failures <= 10)
							$display({"result word %0d mismatch (expected / actual): ",
								"status %0d / %0d, low_power %0d / %0d, ",
								"period_word %0d / %0d, range_a %h / %h, range_b %h / %h"},
								words_checked, want.status, got.status,
								want.low_power, got.low_power,
								want.period_word, got.period_word,
								want.range_a_word, got.range_a_word,
								want.range_b_word, got.range_b_word);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_OSC_FREQ: osc_freq_q = cfg_wdata[OSC_W-1:0];
					REG_PLL_CAL:  pll_cal_q = cfg_wdata[PLL_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_timing_words(
					s_tdata[BUDGET_W-1:0], s_tdata[BUDGET_W+PERIOD_W-1:BUDGET_W]));
		end
		pending = expected_words.size();
	end

endmodule

// File: tb/sv/tb_range_timing_register_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_timing_register_encoder: stream test of the timing register encoder
// A directed pass covers budget limits, both modes, every status and the
// oscillator settings that zero the divisors. Several random configuration
// phases follow with mostly well-formed requests. The sender idles in bursts
// and the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_range_timing_register_encoder;
	import rtre_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_WORDS    = 125;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    failures;
	int                    pending;
	int                    words_checked;
	int                    burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	range_timing_register_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	range_word_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.failures      (failures),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [BUDGET_W-1:0] budget,
			input logic [PERIOD_W-1:0] period);
		s_tdata <= {6'd0, period, budget};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 7))
				0, 1: gap = 0;
				2: gap = $urandom_range(100, 400);
				default: gap = $urandom_range(1, 40);
			endcase
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	// Stops offering words and waits until every result has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] osc,
			input logic [CFG_DATA_W-1:0] pll);
		cfg_we <= 1'b1;
		cfg_idx <= REG_OSC_FREQ;
		cfg_wdata <= osc;
		@(negedge clk);
		cfg_idx <= REG_PLL_CAL;
		cfg_wdata <= pll;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic paced_word(input logic [BUDGET_W-1:0] budget,
			input logic [PERIOD_W-1:0] period);
		pace_sender();
		send_word(budget, period);
	endtask

	initial begin : receiver
		int cyc;
		bit held;
		cyc = 0;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			// One long hold-off lets the block fill up and stall its input.
			if (!held && words_checked >= 200) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (2000) @(negedge clk);
			end
			case ((cyc / 512) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((cyc % 8) < 5);
			endcase
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("[range_timing_register_encoder] ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] osc;
		logic [CFG_DATA_W-1:0] pll;
		logic [BUDGET_W-1:0]   budget;
		logic [PERIOD_W-1:0]   period;
		int                    pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_OSC_FREQ;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers still at reset: a zero oscillator beats every other error.
		paced_word(10'd100, 16'd0);
		paced_word(10'd0, 16'hFFFF);
		drain();

		// The upper bits of the calibrate write must be dropped.
		set_config(16'd4000, 16'hFFFF);
		paced_word(10'd9, 16'd0);
		paced_word(10'd10, 16'd0);
		paced_word(10'd200, 16'd0);
		paced_word(10'd201, 16'd0);
		paced_word(10'd1023, 16'd500);
		paced_word(10'd0, 16'd0);
		paced_word(10'd10, 16'd1);
		paced_word(10'd10, 16'd10);
		paced_word(10'd10, 16'd11);
		paced_word(10'd200, 16'd200);
		paced_word(10'd200, 16'd201);
		paced_word(10'd200, 16'hFFFF);
		drain();

		set_config(16'hFFFF, 16'd0);
		paced_word(10'd10, 16'd0);
		paced_word(10'd10, 16'd11);
		drain();

		// Power-of-two oscillator words up to 64 wrap the macro period to zero.
		set_config(16'd1, 16'd1023);
		paced_word(10'd50, 16'd0);
		drain();
		set_config(16'd64, 16'd512);
		paced_word(10'd50, 16'd1000);
		drain();
		set_config(16'd65, 16'd1);
		paced_word(10'd50, 16'd1000);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: osc = 16'hFFFF;
				1: osc = 16'd1 << $urandom_range(0, 15);
				2: osc = $urandom_range(1, 255);
				default: osc = $urandom_range(256, 65535);
			endcase
			case ($urandom_range(0, 5))
				0: pll = 16'd0;
				1: pll = 16'h03FF;
				default: pll = $urandom_range(0, 65535);
			endcase
			set_config(osc, pll);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					budget = $urandom_range(10, 200);
					case ($urandom_range(0, 2))
						0: period = 16'd0;
						1: period = $urandom_range(budget + 1, budget + 2000);
						default: period = $urandom_range(budget + 1, 65535);
					endcase
				end else if (pick == 8) begin
					budget = $urandom_range(0, 1023);
					period = $urandom_range(0, 65535);
				end else begin
					budget = $urandom_range(10, 200);
					period = $urandom_range(1, budget);
				end
				paced_word(budget, period);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[range_timing_register_encoder] OK");
		else
			$display("[range_timing_register_encoder] ERROR");
		$finish;
	end

endmodule
